// ===== rtl/bounded_double_ended_list_unit_assert.svh =====
// assertion macros for the bounded double-ended list unit
// expects clk and arst_n in the scope of the module that expands them
`ifndef BOUNDED_DOUBLE_ENDED_LIST_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_LIST_UNIT_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define BDEL_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDEL_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/bdel_pkg.sv =====
// shared types and constants for the bounded double-ended list unit
// no dependencies
`default_nettype none

package bdel_pkg;

	// list geometry; the ring pointer wraps by truncation, so capacity is a power of two
	localparam int CAPACITY = 256;
	localparam int ITEM_W   = 32;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;

	// stream word widths, padded to whole bytes
	localparam int S_FIELDS_W = OP_W + ITEM_W + POS_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = STATUS_W + CNT_W + 3 * ITEM_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT_HEAD = 3'd0,
		OP_INSERT_TAIL = 3'd1,
		OP_REMOVE_HEAD = 3'd2,
		OP_REMOVE_TAIL = 3'd3,
		OP_READ_INDEX  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// store access issued by the controller
	typedef struct packed {
		logic              wr_en;
		logic [PTR_W-1:0]  wr_addr;
		logic [ITEM_W-1:0] wr_data;
		logic              rd_en;
		logic [PTR_W-1:0]  rd_addr;
	} ram_req_t;

	// result fields as seen after the last accepted word
	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic [ITEM_W-1:0] read_item;
		logic [ITEM_W-1:0] head_item;
		logic [ITEM_W-1:0] tail_item;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_double_ended_list_unit.sv =====
// Bounded double-ended list unit, top level.
// Request words arrive on the s_axis channel; each asks for insert head,
// insert tail, remove head, remove tail or read by index. Exactly one result
// word per request leaves on the m_axis channel, carrying status, the new
// count, the read item and the current head and tail items.
// The result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; every
// operation makes at most one access to the single-write, single-read ring
// store, and the head and tail items are cached in registers, with a removal
// fetching the new end item through the store read port.
// Reset empties the list at once (count and head pointer cleared); the store
// needs no clearing pass since only slots written by inserts are ever read.
// When the receiver stalls, the result word is held and s_axis_tready drops
// until it is taken; a result taken in the same cycle frees the slot for the
// next request.
// Depends on bdel_pkg, bdel_ctrl and bdel_ram.
`default_nettype none

module bounded_double_ended_list_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// operation, item, position
	input  wire logic [bdel_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// status, count, read_item, head_item, tail_item
	output logic      [bdel_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	import bdel_pkg::*;

	logic              accept;
	logic              out_valid_q;
	op_t               op;
	logic [ITEM_W-1:0] item;
	logic [POS_W-1:0]  position;
	logic [ITEM_W-1:0] rd_data;
	ram_req_t          ram_req;
	result_t           result;

	// request word fields
	assign op       = op_t'(s_axis_tdata[OP_W-1:0]);
	assign item     = s_axis_tdata[OP_W +: ITEM_W];
	assign position = s_axis_tdata[OP_W + ITEM_W +: POS_W];

	// handshake: the result slot is free or being emptied this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	bdel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.item     (item),
		.position (position),
		.rd_data  (rd_data),
		.ram_req  (ram_req),
		.result   (result)
	);

	bdel_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ITEM_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	// result word packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
		result.tail_item, result.head_item, result.read_item,
		result.count, result.status};

endmodule

`default_nettype wire

// ===== rtl/bdel_ram.sv =====
// ring store: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module bdel_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bdel_ctrl.sv =====
// list controller: count, ring head pointer, cached head and tail items
// depends on bdel_pkg and the assertion macro header
`default_nettype none

module bdel_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire bdel_pkg::op_t             op,
	input  wire logic [bdel_pkg::ITEM_W-1:0] item,
	input  wire logic [bdel_pkg::POS_W-1:0]  position,
	input  wire logic [bdel_pkg::ITEM_W-1:0] rd_data,
	output bdel_pkg::ram_req_t             ram_req,
	output bdel_pkg::result_t              result
);

	import bdel_pkg::*;

	logic [CNT_W-1:0]  count_q, count_n;
	logic [PTR_W-1:0]  ptr_q, ptr_n;
	logic [ITEM_W-1:0] head_q, head_n, tail_q, tail_n;
	logic              head_mem_q, head_mem_n;
	logic              tail_mem_q, tail_mem_n;
	logic              is_read_q, is_read_n;
	status_t           status_q, status_n;
	logic [ITEM_W-1:0] eff_head, eff_tail;
	logic              empty, full;
	logic [CNT_W-1:0]  count_m2;

	// head or tail may still sit in the read register after a removal
	assign eff_head = head_mem_q ? rd_data : head_q;
	assign eff_tail = tail_mem_q ? rd_data : tail_q;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign count_m2 = count_q - CNT_W'(2);

	// operation decode and next state
	always_comb begin
		count_n         = count_q;
		ptr_n           = ptr_q;
		head_n          = eff_head;
		tail_n          = eff_tail;
		head_mem_n      = 1'b0;
		tail_mem_n      = 1'b0;
		is_read_n       = 1'b0;
		status_n        = ST_OK;
		ram_req.wr_en   = 1'b0;
		ram_req.wr_addr = ptr_q;
		ram_req.wr_data = item;
		ram_req.rd_en   = 1'b0;
		ram_req.rd_addr = ptr_q;
		unique case (op)
			OP_INSERT_HEAD: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					ptr_n           = ptr_q - PTR_W'(1);
					ram_req.wr_en   = accept;
					ram_req.wr_addr = ptr_q - PTR_W'(1);
					count_n         = count_q + CNT_W'(1);
					head_n          = item;
					if (empty) begin
						tail_n = item;
					end
				end
			end
			OP_INSERT_TAIL: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					ram_req.wr_en   = accept;
					ram_req.wr_addr = ptr_q + count_q[PTR_W-1:0];
					count_n         = count_q + CNT_W'(1);
					tail_n          = item;
					if (empty) begin
						head_n = item;
					end
				end
			end
			OP_REMOVE_HEAD: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					ptr_n   = ptr_q + PTR_W'(1);
					count_n = count_q - CNT_W'(1);
					// fetch the new head unless the list drains
					if (count_q > CNT_W'(1)) begin
						ram_req.rd_en   = accept;
						ram_req.rd_addr = ptr_q + PTR_W'(1);
						head_mem_n      = 1'b1;
					end
				end
			end
			OP_REMOVE_TAIL: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					count_n = count_q - CNT_W'(1);
					if (count_q > CNT_W'(1)) begin
						ram_req.rd_en   = accept;
						ram_req.rd_addr = ptr_q + count_m2[PTR_W-1:0];
						tail_mem_n      = 1'b1;
					end
				end
			end
			OP_READ_INDEX: begin
				if (CNT_W'(position) >= count_q) begin
					status_n = ST_RANGE;
				end else begin
					ram_req.rd_en   = accept;
					ram_req.rd_addr = ptr_q + PTR_W'(position);
					is_read_n       = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			head_mem_q <= 1'b0;
			tail_mem_q <= 1'b0;
			is_read_q  <= 1'b0;
			status_q   <= ST_OK;
		end else if (accept) begin
			count_q    <= count_n;
			ptr_q      <= ptr_n;
			head_mem_q <= head_mem_n;
			tail_mem_q <= tail_mem_n;
			is_read_q  <= is_read_n;
			status_q   <= status_n;
		end
	end

	// cached end items
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= head_n;
			tail_q <= tail_n;
		end
	end

	// result view, stable while no word is accepted
	assign result.status    = status_q;
	assign result.count     = count_q;
	assign result.read_item = is_read_q ? rd_data : '0;
	assign result.head_item = empty ? '0 : eff_head;
	assign result.tail_item = empty ? '0 : eff_tail;

	`include "bounded_double_ended_list_unit_assert.svh"

	`BDEL_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`BDEL_ASSERT_ALWAYS(a_one_fetch, !(head_mem_q && tail_mem_q), "head and tail both pending")
	`BDEL_ASSERT_NEXT(a_insert_grows,
		accept && !full && (op == OP_INSERT_HEAD || op == OP_INSERT_TAIL),
		count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
	`BDEL_ASSERT_NEXT(a_empty_remove,
		accept && empty && (op == OP_REMOVE_HEAD || op == OP_REMOVE_TAIL),
		count_q == '0 && status_q == ST_EMPTY, "removal from empty list changed state")

endmodule

`default_nettype wire
